### hw/rtl/pct_pkg.sv
// Shared types, constants and the prescaler divisor table for the
// prescaled compare timer. No dependencies; used by pct_channel and the top level.
`default_nettype none

package pct_pkg;

    // Number of compare channels
    localparam int CHANNELS = 2;

    // Field widths
    localparam int COUNT_W    = 16;
    localparam int HIGH_W     = 48;
    localparam int PRESCALE_W = 13;
    localparam int DIVISOR_W  = 14;
    localparam int SELECT_W   = 3;

    // Stream widths
    localparam int IN_TDATA_W  = 24;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 72;

    // Shortest period that arm accepts is one above this
    localparam logic [COUNT_W-1:0] ARM_MIN  = 16'd2;
    localparam logic [COUNT_W-1:0] LOW_MAX  = 16'hFFFF;

    // Operation codes carried on the input tuser
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_ARM    = 2'd2,
        OP_DISARM = 2'd3
    } pct_op_t;

    // Configuration register indexes
    localparam logic CFG_PRESCALE = 1'b0;
    localparam logic CFG_ENABLE   = 1'b1;

    // Per-channel command for one accepted beat
    typedef struct packed {
        logic advance;
        logic arm;
        logic disarm;
        logic continuous;
    } pct_chan_cmd_t;

    // Result beat, tick_count in the lowest bits
    typedef struct packed {
        logic               arm_ok;
        logic               hit_one;
        logic               hit_zero;
        logic               overflow_event;
        logic [63:0]        tick_count;
    } pct_result_t;

    localparam int RESULT_W = $bits(pct_result_t);

    // Divisor for each prescaler choice; the two unused choices (6 and 7) divide by 8192
    function automatic logic [DIVISOR_W-1:0] divisor(input logic [SELECT_W-1:0] sel);
        logic [DIVISOR_W-1:0] d;
        case (sel)
            3'd0:    d = 14'd1;
            3'd1:    d = 14'd2;
            3'd2:    d = 14'd8;
            3'd3:    d = 14'd32;
            3'd4:    d = 14'd64;
            3'd5:    d = 14'd1024;
            default: d = 14'd8192;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/prescaled_compare_timer.sv
// Top level of the prescaled compare timer: prescaler, 64-bit tick count,
// compare channels and a two-entry result buffer. Depends on pct_pkg, pct_channel.
//
// Usage:
//   s_axis carries one command per beat: tuser holds the operation (base tick,
//   clear, arm, disarm); tdata holds channel, period and continuous mode.
//   m_axis returns exactly one result beat per command: the 64-bit tick count
//   after the command, the overflow flag, the two compare hits and arm_ok.
//   cfg writes prescale_select (index 0) and count_enable (index 1); cfg_ready
//   is always high. Write configuration only while no command is in flight.
// Timing:
//   The result beat is registered from the accepted command beat. The block takes
//   one command every cycle while the skid register is empty; all counter and
//   channel state updates in the cycle a command is accepted, so the next command sees it at once.
// Reset:
//   Counts and prescaler clear, divide by 1 is selected, counting is enabled,
//   and all channels come up disarmed.
// Stall:
//   When m_axis_tready is low the result register holds, one more result goes
//   into the skid register, and s_axis_tready drops only while that is full.
`default_nettype none

module prescaled_compare_timer (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Command stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [0] channel, [16:1] period, [17] continuous, [23:18] zero
    input  wire logic [pct_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [1:0] operation
    input  wire logic [pct_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    // Result stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [63:0] tick_count, [64] overflow_event, [65] hit_zero, [66] hit_one,
    // [67] arm_ok, [71:68] zero
    output logic [pct_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    // Configuration writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic                              cfg_index,
    input  wire logic [pct_pkg::SELECT_W-1:0]      cfg_data
);

    // Configuration registers
    logic [pct_pkg::SELECT_W-1:0]   prescale_select_reg;
    logic                           count_enable_reg;

    // Counter state
    logic [pct_pkg::PRESCALE_W-1:0] prescale_count_reg;
    logic [pct_pkg::PRESCALE_W-1:0] prescale_count_next;
    logic [pct_pkg::COUNT_W-1:0]    low_count_reg;
    logic [pct_pkg::COUNT_W-1:0]    low_count_next;
    logic [pct_pkg::HIGH_W-1:0]     high_count_reg;
    logic [pct_pkg::HIGH_W-1:0]     high_count_next;

    // Result buffer
    logic                           out_valid_reg;
    pct_pkg::pct_result_t           out_data_reg;
    logic                           skid_valid_reg;
    pct_pkg::pct_result_t           skid_data_reg;
    pct_pkg::pct_result_t           res_next;

    // Decoded command
    logic                           in_accept;
    logic                           out_take;
    pct_pkg::pct_op_t               op;
    logic                           in_channel;
    logic [pct_pkg::COUNT_W-1:0]    in_period;
    logic                           in_continuous;
    logic                           is_tick;
    logic                           is_clear;
    logic                           is_arm;
    logic                           is_disarm;
    logic                           ch_in_range;
    logic                           period_ok;
    logic                           arm_ok;

    // Counting
    logic [pct_pkg::DIVISOR_W-1:0]  pre_inc;
    logic                           do_count;
    logic                           advance;
    logic [pct_pkg::COUNT_W-1:0]    low_adv;
    logic                           overflow;

    logic [pct_pkg::CHANNELS-1:0]   hits;
    logic [1:0]                     hit_pair;

    // Handshakes
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_take      = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = !skid_valid_reg;
    assign cfg_ready     = 1'b1;

    // Unpack the command beat
    assign op            = pct_pkg::pct_op_t'(s_axis_tuser[1:0]);
    assign in_channel    = s_axis_tdata[0];
    assign in_period     = s_axis_tdata[16:1];
    assign in_continuous = s_axis_tdata[17];

    // Decode the operation
    always_comb
    begin
        is_tick   = 1'b0;
        is_clear  = 1'b0;
        is_arm    = 1'b0;
        is_disarm = 1'b0;
        unique case (op)
            pct_pkg::OP_TICK:   is_tick   = 1'b1;
            pct_pkg::OP_CLEAR:  is_clear  = 1'b1;
            pct_pkg::OP_ARM:    is_arm    = 1'b1;
            pct_pkg::OP_DISARM: is_disarm = 1'b1;
            default:            is_tick   = 1'b0;
        endcase
    end

    assign ch_in_range = (32'(in_channel) < pct_pkg::CHANNELS);
    assign period_ok   = (in_period > pct_pkg::ARM_MIN);
    assign arm_ok      = is_arm && ch_in_range && period_ok;

    // Prescaler and counter step
    assign pre_inc  = {1'b0, prescale_count_reg} + 14'd1;
    assign do_count = in_accept && is_tick && count_enable_reg;
    assign advance  = do_count && (pre_inc >= pct_pkg::divisor(prescale_select_reg));
    assign low_adv  = low_count_reg + 16'd1;
    assign overflow = advance && (low_count_reg == pct_pkg::LOW_MAX);

    always_comb
    begin
        prescale_count_next = prescale_count_reg;
        low_count_next      = low_count_reg;
        high_count_next     = high_count_reg;
        if (in_accept && is_clear)
        begin
            prescale_count_next = '0;
            low_count_next      = '0;
            high_count_next     = '0;
        end
        else if (advance)
        begin
            prescale_count_next = '0;
            low_count_next      = low_adv;
            if (overflow)
            begin
                high_count_next = high_count_reg + 48'd1;
            end
        end
        else if (do_count)
        begin
            prescale_count_next = pre_inc[pct_pkg::PRESCALE_W-1:0];
        end
    end

    // Compare channels
    for (genvar c = 0; c < pct_pkg::CHANNELS; c++)
    begin : g_chan
        pct_pkg::pct_chan_cmd_t cmd;
        logic                   sel;

        assign sel            = (32'(in_channel) == c);
        assign cmd.advance    = advance;
        assign cmd.arm        = in_accept && arm_ok && sel;
        assign cmd.disarm     = in_accept && is_disarm && sel;
        assign cmd.continuous = in_continuous;

        pct_channel u_channel (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .period    (in_period),
            .count_now (low_count_reg),
            .count_adv (low_adv),
            .hit       (hits[c])
        );
    end

    assign hit_pair = 2'(hits);

    // Assemble the result beat
    always_comb
    begin
        res_next.tick_count     = {high_count_next, low_count_next};
        res_next.overflow_event = overflow;
        res_next.hit_zero       = hit_pair[0];
        res_next.hit_one        = hit_pair[1];
        res_next.arm_ok         = arm_ok;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_select_reg <= '0;
            count_enable_reg    <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pct_pkg::CFG_PRESCALE: prescale_select_reg <= cfg_data;
                pct_pkg::CFG_ENABLE:   count_enable_reg    <= cfg_data[0];
                default:               count_enable_reg    <= count_enable_reg;
            endcase
        end
    end

    // Counter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_count_reg <= '0;
            low_count_reg      <= '0;
            high_count_reg     <= '0;
        end
        else
        begin
            prescale_count_reg <= prescale_count_next;
            low_count_reg      <= low_count_next;
            high_count_reg     <= high_count_next;
        end
    end

    // Result and skid valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                // Drain the skid into the result register
                if (out_take)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (in_accept)
            begin
                if (out_valid_reg && !out_take)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result and skid payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (in_accept)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_data_reg <= res_next;
            end
            else
            begin
                out_data_reg <= res_next;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(pct_pkg::OUT_TDATA_W - pct_pkg::RESULT_W)'(0), out_data_reg};

`ifndef SYNTHESIS
    // A held skid beat always has a result ahead of it
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid beat held without a result ahead of it");

    // Clear leaves the whole tick count at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && is_clear) |=> (low_count_reg == '0 && high_count_reg == '0))
        else $error("clear did not zero the tick count");

    // Overflow flags only a result whose low count wrapped to zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.overflow_event) |->
            (out_data_reg.tick_count[15:0] == 16'd0))
        else $error("overflow flagged with nonzero low count");

    // An accepted arm never comes with counter events
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.arm_ok) |->
            (!out_data_reg.overflow_event && !out_data_reg.hit_zero && !out_data_reg.hit_one))
        else $error("arm result carries counter events");
`endif

endmodule

`default_nettype wire

### hw/rtl/pct_channel.sv
// One compare channel: armed flag, mode, period and compare value.
// Depends on pct_pkg for the command struct and widths.
`default_nettype none

module pct_channel (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire pct_pkg::pct_chan_cmd_t        cmd,
    input  wire logic [pct_pkg::COUNT_W-1:0]   period,
    input  wire logic [pct_pkg::COUNT_W-1:0]   count_now,
    input  wire logic [pct_pkg::COUNT_W-1:0]   count_adv,
    output logic                               hit
);

    logic                          armed_reg;
    logic                          armed_next;
    logic                          repeat_reg;
    logic                          repeat_next;
    logic [pct_pkg::COUNT_W-1:0]   compare_value_reg;
    logic [pct_pkg::COUNT_W-1:0]   compare_value_next;
    logic [pct_pkg::COUNT_W-1:0]   repeat_period_reg;
    logic [pct_pkg::COUNT_W-1:0]   repeat_period_next;

    // Match when the counter steps onto the compare value
    assign hit = cmd.advance && armed_reg && (compare_value_reg == count_adv);

    // Next channel state: arm, disarm, re-arm or drop after a match
    always_comb
    begin
        armed_next         = armed_reg;
        repeat_next        = repeat_reg;
        compare_value_next = compare_value_reg;
        repeat_period_next = repeat_period_reg;
        if (cmd.arm)
        begin
            armed_next         = 1'b1;
            repeat_next        = cmd.continuous;
            repeat_period_next = period;
            compare_value_next = period + count_now;
        end
        else if (cmd.disarm)
        begin
            armed_next         = 1'b0;
            compare_value_next = '0;
        end
        else if (hit)
        begin
            if (repeat_reg)
            begin
                compare_value_next = repeat_period_reg + count_adv;
            end
            else
            begin
                armed_next         = 1'b0;
                compare_value_next = '0;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg  <= 1'b0;
            repeat_reg <= 1'b0;
        end
        else
        begin
            armed_reg  <= armed_next;
            repeat_reg <= repeat_next;
        end
    end

    // Payload: only read while armed
    always_ff @(posedge clk)
    begin
        compare_value_reg <= compare_value_next;
        repeat_period_reg <= repeat_period_next;
    end

endmodule

`default_nettype wire
